@@ src/kst_pkg.sv @@
// Shared types, codes, constants and scan tables for the keyboard state block.
package kst_pkg;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_KEY   = 2'd0,
        OP_TICK  = 2'd1,
        OP_XLATE = 2'd2
    } t_op;

    // Configuration register indexes
    localparam logic [1:0] CFG_DELAY  = 2'd0;
    localparam logic [1:0] CFG_PERIOD = 2'd1;
    localparam logic [1:0] CFG_MASK   = 2'd2;

    // Reset values of the delay and period configuration registers
    localparam logic [15:0] DELAY_RESET  = 16'd500;
    localparam logic [15:0] PERIOD_RESET = 16'd33;

    // Key codes with a role of their own
    localparam logic [8:0] CODE_CAPS   = 9'h03a;
    localparam logic [8:0] CODE_C      = 9'h02e;
    localparam logic [8:0] CODE_LCTRL  = 9'h01d;
    localparam logic [8:0] CODE_RCTRL  = 9'h11d;
    localparam logic [8:0] CODE_LSHIFT = 9'h02a;
    localparam logic [8:0] CODE_RSHIFT = 9'h036;

    localparam logic [2:0] COUNT_MAX = 3'd7;
    localparam logic [6:0] TABLE_LEN = 7'h54;

    // Special key numbers
    localparam logic [3:0] SK_NONE  = 4'd0;
    localparam logic [3:0] SK_UP    = 4'd1;
    localparam logic [3:0] SK_DOWN  = 4'd2;
    localparam logic [3:0] SK_LEFT  = 4'd3;
    localparam logic [3:0] SK_RIGHT = 4'd4;
    localparam logic [3:0] SK_HOME  = 4'd5;
    localparam logic [3:0] SK_END   = 4'd6;
    localparam logic [3:0] SK_PGUP  = 4'd7;
    localparam logic [3:0] SK_PGDN  = 4'd8;
    localparam logic [3:0] SK_DEL   = 4'd9;
    localparam logic [3:0] SK_INS   = 4'd10;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic [1:0] pad;
        logic [3:0] special_key;
        logic [6:0] character;
        logic       interrupt_request;
        logic [7:0] scan_byte;
        logic       extended;
        logic       delivered;
    } t_result;

    // Modifier and lock state seen by the translator
    typedef struct packed {
        logic [3:0] modifier_held;
        logic       caps_lock_on;
    } t_kbd_mode;

    // Translator answer
    typedef struct packed {
        logic [6:0] character;
        logic [3:0] special_key;
    } t_xlate_res;

    // Keys that never arm auto-repeat
    function automatic logic is_modifier(input logic [8:0] c);
        return c == 9'h02a || c == 9'h036 || c == 9'h01d || c == 9'h11d ||
               c == 9'h038 || c == 9'h138 || c == 9'h15b || c == 9'h15c ||
               c == 9'h03a || c == 9'h045 || c == 9'h046;
    endfunction

    // Unshifted set-1 map
    function automatic logic [6:0] plain_map(input logic [6:0] idx);
        logic [6:0] ch;
        case (idx)
            7'h01: ch = 7'h1b;
            7'h02: ch = 7'h31;
            7'h03: ch = 7'h32;
            7'h04: ch = 7'h33;
            7'h05: ch = 7'h34;
            7'h06: ch = 7'h35;
            7'h07: ch = 7'h36;
            7'h08: ch = 7'h37;
            7'h09: ch = 7'h38;
            7'h0a: ch = 7'h39;
            7'h0b: ch = 7'h30;
            7'h0c: ch = 7'h2d;
            7'h0d: ch = 7'h3d;
            7'h0e: ch = 7'h08;
            7'h0f: ch = 7'h09;
            7'h10: ch = 7'h71;
            7'h11: ch = 7'h77;
            7'h12: ch = 7'h65;
            7'h13: ch = 7'h72;
            7'h14: ch = 7'h74;
            7'h15: ch = 7'h79;
            7'h16: ch = 7'h75;
            7'h17: ch = 7'h69;
            7'h18: ch = 7'h6f;
            7'h19: ch = 7'h70;
            7'h1a: ch = 7'h5b;
            7'h1b: ch = 7'h5d;
            7'h1c: ch = 7'h0a;
            7'h1e: ch = 7'h61;
            7'h1f: ch = 7'h73;
            7'h20: ch = 7'h64;
            7'h21: ch = 7'h66;
            7'h22: ch = 7'h67;
            7'h23: ch = 7'h68;
            7'h24: ch = 7'h6a;
            7'h25: ch = 7'h6b;
            7'h26: ch = 7'h6c;
            7'h27: ch = 7'h3b;
            7'h28: ch = 7'h27;
            7'h29: ch = 7'h60;
            7'h2b: ch = 7'h5c;
            7'h2c: ch = 7'h7a;
            7'h2d: ch = 7'h78;
            7'h2e: ch = 7'h63;
            7'h2f: ch = 7'h76;
            7'h30: ch = 7'h62;
            7'h31: ch = 7'h6e;
            7'h32: ch = 7'h6d;
            7'h33: ch = 7'h2c;
            7'h34: ch = 7'h2e;
            7'h35: ch = 7'h2f;
            7'h37: ch = 7'h2a;
            7'h39: ch = 7'h20;
            7'h47: ch = 7'h37;
            7'h48: ch = 7'h38;
            7'h49: ch = 7'h39;
            7'h4a: ch = 7'h2d;
            7'h4b: ch = 7'h34;
            7'h4c: ch = 7'h35;
            7'h4d: ch = 7'h36;
            7'h4e: ch = 7'h2b;
            7'h4f: ch = 7'h31;
            7'h50: ch = 7'h32;
            7'h51: ch = 7'h33;
            7'h52: ch = 7'h30;
            7'h53: ch = 7'h2e;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    // Shifted set-1 map: letters go upper case, punctuation differs
    function automatic logic [6:0] shift_map(input logic [6:0] idx);
        logic [6:0] p;
        logic [6:0] ch;
        p = plain_map(idx);
        case (idx)
            7'h02: ch = 7'h21;
            7'h03: ch = 7'h40;
            7'h04: ch = 7'h23;
            7'h05: ch = 7'h24;
            7'h06: ch = 7'h25;
            7'h07: ch = 7'h5e;
            7'h08: ch = 7'h26;
            7'h09: ch = 7'h2a;
            7'h0a: ch = 7'h28;
            7'h0b: ch = 7'h29;
            7'h0c: ch = 7'h5f;
            7'h0d: ch = 7'h2b;
            7'h1a: ch = 7'h7b;
            7'h1b: ch = 7'h7d;
            7'h27: ch = 7'h3a;
            7'h28: ch = 7'h22;
            7'h29: ch = 7'h7e;
            7'h2b: ch = 7'h7c;
            7'h33: ch = 7'h3c;
            7'h34: ch = 7'h3e;
            7'h35: ch = 7'h3f;
            default: begin
                if (p >= 7'h61 && p <= 7'h7a) begin
                    ch = p - 7'h20;
                end else begin
                    ch = p;
                end
            end
        endcase
        return ch;
    endfunction

endpackage

@@ src/kst_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module kst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read, old data on a collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/kst_xlate.sv @@
// Set-1 scan byte translator: Shift, Caps Lock, Ctrl folding and special keys.
module kst_xlate
    import kst_pkg::*;
(
    input  logic [7:0] i_scan,
    input  t_kbd_mode  i_mode,
    output t_xlate_res o_res
);

    logic       shifted;
    logic [6:0] plain;
    logic [6:0] ch;
    logic [6:0] up;

    always_comb begin
        o_res   = '0;
        plain   = plain_map(i_scan[6:0]);
        shifted = i_mode.modifier_held[1:0] != 2'b00;
        ch      = 7'h00;
        up      = 7'h00;
        if (i_scan[7]) begin
            // Extended keys: navigation block, keypad Enter and slash
            case (i_scan[6:0])
                7'h48: o_res.special_key = SK_UP;
                7'h50: o_res.special_key = SK_DOWN;
                7'h4b: o_res.special_key = SK_LEFT;
                7'h4d: o_res.special_key = SK_RIGHT;
                7'h47: o_res.special_key = SK_HOME;
                7'h4f: o_res.special_key = SK_END;
                7'h49: o_res.special_key = SK_PGUP;
                7'h51: o_res.special_key = SK_PGDN;
                7'h53: o_res.special_key = SK_DEL;
                7'h52: o_res.special_key = SK_INS;
                7'h1c: o_res.character   = 7'h0a;
                7'h35: o_res.character   = 7'h2f;
                default: o_res.special_key = SK_NONE;
            endcase
        end else if (i_scan[6:0] < TABLE_LEN) begin
            // Caps Lock flips Shift on letters only
            if (plain >= 7'h61 && plain <= 7'h7a && i_mode.caps_lock_on) begin
                shifted = !shifted;
            end
            ch = shifted ? shift_map(i_scan[6:0]) : plain;
            // Ctrl folds to control codes
            if (i_mode.modifier_held[3:2] != 2'b00) begin
                up = (ch >= 7'h61 && ch <= 7'h7a) ? ch - 7'h20 : ch;
                if (up >= 7'h40 && up <= 7'h5f) begin
                    ch = up & 7'h1f;
                end else if (up == 7'h3f) begin
                    ch = 7'h7f;
                end else if (up == 7'h20) begin
                    ch = 7'h00;
                end else begin
                    ch = up;
                end
            end
            o_res.character = ch;
        end
    end

endmodule

@@ src/keyboard_state_and_translate.sv @@
// Top level: keyboard key state, software auto-repeat and scan translation.
//
// Takes one item per clock cycle while the output side is not stalled and
// returns one result item for each, through the stage register and then the
// output register. The per-key state (one down bit per source plus a
// saturating hold count) lives in a single RAM of KEY_CODES words, read when
// an item is accepted and written back when the item leaves the stage; a
// one-entry forward register covers a key event that follows another on the
// same code. Modifier, Caps Lock and repeat state sit in flip-flops. After
// reset the block sweeps the RAM to zero, one word per cycle, during which no
// item is taken; configuration writes are taken at any time.
module keyboard_state_and_translate
    import kst_pkg::*;
#(
    parameter int SOURCES   = 4,
    parameter int KEY_CODES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Item input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // source[1:0], key_code[10:2], pressed[11],
                                    // scan_byte_in[19:12], zero[23:20]
    input  logic [1:0]  i_s_tuser,  // operation[1:0]
    // Result output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,  // delivered[0], extended[1], scan_byte[9:2],
                                    // interrupt_request[10], character[17:11],
                                    // special_key[21:18], zero[23:22]
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(KEY_CODES);
    localparam int DW = SOURCES + 3;
    localparam logic [AW-1:0] LAST_ADDR = AW'(KEY_CODES - 1);

    // Configuration registers
    logic [15:0] r_delay;
    logic [15:0] r_period;
    logic [3:0]  r_mask;

    // Clearing sweep
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    // Stage holding the item whose RAM word is being read
    logic       r_s1_valid;
    logic [1:0] r_s1_op;
    logic [1:0] r_s1_src;
    logic [8:0] r_s1_code;
    logic       r_s1_pressed;
    logic [7:0] r_s1_scan;

    // Forward register: last word written
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    logic [DW-1:0] r_fwd_data;

    // Keyboard state
    logic        r_caps;
    logic [3:0]  r_mod;
    logic        r_armed;
    logic [1:0]  r_owner;
    logic [8:0]  r_rkey;
    logic [15:0] r_count;
    logic        n_caps;
    logic [3:0]  n_mod;
    logic        n_armed;
    logic [1:0]  n_owner;
    logic [8:0]  n_rkey;
    logic [15:0] n_count;

    // Output register
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic          in_acc;
    logic          adv;
    logic          step;
    logic [AW-1:0] s1_addr;
    logic [AW-1:0] raddr;
    logic [DW-1:0] rdata;
    logic [DW-1:0] old_word;
    logic [DW-1:0] new_word;
    logic [2:0]    old_cnt;
    logic [2:0]    new_cnt;
    logic          src_down;
    logic          ev_ok;
    logic          skip;
    logic          upd_we;
    logic          ram_we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    t_kbd_mode     mode;
    t_xlate_res    xres;

    assign adv        = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_clearing && (!r_s1_valid || adv);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign step       = r_s1_valid && adv;
    assign o_cfg_ready = 1'b1;

    assign s1_addr = r_s1_code[AW-1:0];
    // Re-read the held item's word while stalled
    assign raddr   = in_acc ? i_s_tdata[AW+1:2] : s1_addr;

    // Write port: clearing sweep or stage write-back
    assign ram_we = r_clearing || (step && upd_we);
    assign waddr  = r_clearing ? r_clr_addr : s1_addr;
    assign wdata  = r_clearing ? '0 : new_word;

    kst_ram #(
        .WIDTH(DW),
        .DEPTH(KEY_CODES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign mode.modifier_held = r_mod;
    assign mode.caps_lock_on  = r_caps;

    kst_xlate u_xlate (
        .i_scan(r_s1_scan),
        .i_mode(mode),
        .o_res (xres)
    );

    // Forward the last write over the stale read
    assign old_word = (r_fwd_valid && r_fwd_addr == s1_addr) ? r_fwd_data : rdata;
    assign old_cnt  = old_word[2:0];

    always_comb begin
        src_down = 1'b0;
        for (int s = 0; s < SOURCES; s++) begin
            if ({2'b00, r_s1_src} == 4'(s)) begin
                src_down = old_word[s+3];
            end
        end
    end

    assign ev_ok = r_s1_code != 9'd0 && {1'b0, r_s1_code} < 10'(KEY_CODES) &&
                   {3'b000, r_s1_src} < 5'(SOURCES);

    // Process the item in the stage
    always_comb begin
        n_caps   = r_caps;
        n_mod    = r_mod;
        n_armed  = r_armed;
        n_owner  = r_owner;
        n_rkey   = r_rkey;
        n_count  = r_count;
        n_out    = '0;
        new_word = old_word;
        new_cnt  = old_cnt;
        upd_we   = 1'b0;
        skip     = 1'b0;
        case (r_s1_op)
            OP_KEY: begin
                if (ev_ok && (r_s1_pressed || src_down)) begin
                    if (r_s1_pressed != src_down) begin
                        upd_we = 1'b1;
                        if (r_s1_pressed) begin
                            if (old_cnt == 3'd0 && r_s1_code == CODE_CAPS) begin
                                n_caps = !r_caps;
                            end
                            new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 3'd1;
                        end else begin
                            new_cnt = (old_cnt != 3'd0) ? old_cnt - 3'd1 : 3'd0;
                            skip    = new_cnt != 3'd0;
                        end
                        for (int s = 0; s < SOURCES; s++) begin
                            if ({2'b00, r_s1_src} == 4'(s)) begin
                                new_word[s+3] = r_s1_pressed;
                            end
                        end
                        new_word[2:0] = new_cnt;
                        // Refresh the held modifier this code stands for
                        if (r_s1_code == CODE_LSHIFT) n_mod[0] = new_cnt != 3'd0;
                        if (r_s1_code == CODE_RSHIFT) n_mod[1] = new_cnt != 3'd0;
                        if (r_s1_code == CODE_LCTRL)  n_mod[2] = new_cnt != 3'd0;
                        if (r_s1_code == CODE_RCTRL)  n_mod[3] = new_cnt != 3'd0;
                    end
                    if (!skip) begin
                        // Arm or drop the software repeat
                        if (r_s1_pressed && r_mask[r_s1_src] && !is_modifier(r_s1_code)) begin
                            n_armed = 1'b1;
                            n_owner = r_s1_src;
                            n_rkey  = r_s1_code;
                            n_count = r_delay;
                        end else if (!r_s1_pressed && r_armed && r_owner == r_s1_src &&
                                     r_rkey == r_s1_code) begin
                            n_armed = 1'b0;
                        end
                        n_out.interrupt_request = r_s1_pressed && r_s1_code == CODE_C &&
                                                  r_mod[3:2] != 2'b00;
                        n_out.delivered = 1'b1;
                        n_out.extended  = r_s1_code[8];
                        n_out.scan_byte = {!r_s1_pressed, r_s1_code[6:0]};
                    end
                end
            end
            OP_TICK: begin
                if (r_armed) begin
                    if (r_count <= 16'd1) begin
                        n_count         = r_period;
                        n_out.delivered = 1'b1;
                        n_out.extended  = r_rkey[8];
                        n_out.scan_byte = {1'b0, r_rkey[6:0]};
                    end else begin
                        n_count = r_count - 16'd1;
                    end
                end
            end
            OP_XLATE: begin
                n_out.character   = xres.character;
                n_out.special_key = xres.special_key;
            end
            default: n_out = '0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay     <= DELAY_RESET;
            r_period    <= PERIOD_RESET;
            r_mask      <= 4'd0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_caps      <= 1'b0;
            r_mod       <= 4'd0;
            r_armed     <= 1'b0;
            r_owner     <= 2'd0;
            r_rkey      <= 9'd0;
            r_count     <= 16'd0;
        end else begin
            // Take configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_DELAY:  r_delay  <= i_cfg_data;
                    CFG_PERIOD: r_period <= i_cfg_data;
                    CFG_MASK:   r_mask   <= i_cfg_data[3:0];
                    default:    r_mask   <= r_mask;
                endcase
            end
            // Advance the clearing sweep
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end
            end
            // Stage occupancy
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (step) begin
                r_s1_valid <= 1'b0;
            end
            // Commit the stage
            if (step) begin
                r_caps  <= n_caps;
                r_mod   <= n_mod;
                r_armed <= n_armed;
                r_owner <= n_owner;
                r_rkey  <= n_rkey;
                r_count <= n_count;
                if (upd_we) begin
                    r_fwd_valid <= 1'b1;
                end
            end
            // Output register occupancy
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op      <= i_s_tuser;
            r_s1_src     <= i_s_tdata[1:0];
            r_s1_code    <= i_s_tdata[10:2];
            r_s1_pressed <= i_s_tdata[11];
            r_s1_scan    <= i_s_tdata[19:12];
        end
        if (step && upd_we) begin
            r_fwd_addr <= s1_addr;
            r_fwd_data <= new_word;
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule
